// File: design/bfra_pkg.sv
// Shared types and constants for the best-fit range allocator.
// No dependencies; the top level refers to it by scoped names.
package bfra_pkg;

    // End of the managed address space and the allocation grain.
    localparam logic [23:0] MEM_END    = 24'h400000;
    localparam logic [23:0] GRAIN_MASK = 24'd255;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_EVICT = 2'd2;

    // Configuration register indexes.
    localparam logic REG_ARENA_BASE = 1'b0;
    localparam logic REG_ARENA_TOP  = 1'b1;

    // One free-list entry as held in the list memory.
    typedef struct packed {
        logic [22:0] len;
        logic [21:0] start;
    } entry_t;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

endpackage

// File: design/best_fit_range_allocator_top.sv
// Top level of the best-fit range allocator: controller, registers and list memory.
// Depends on bfra_pkg and bfra_ram.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid/s_tready    tuser: operation; tdata: address, size
//   m_        out        m_tvalid/m_tready    tuser: failed; tdata: grant, free_blocks
//   cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// One transaction at a time. Allocate scans the whole free list and, on an exact fit,
// moves the entries above the taken one down; free scans up to the insertion point and
// moves entries when a plain insert opens a slot or a bridging merge closes one. The
// free-list memory has a single read port, so entries are read one at a time.
// Reset is synchronous; the list memory needs no clearing pass, since only entries
// below free_count are read. A stalled result holds the controller in its last state.
module best_fit_range_allocator_top #(
    parameter int FREE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [21:0] range_address, [44:22] range_size
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [21:0] granted_address, [30:22] free_blocks
    output logic        m_tuser,   // [0] failed
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [22:0] cfg_wdata
);

    localparam int IW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int CW = $clog2(FREE_ENTRIES + 1);

    bfra_pkg::state_t state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [21:0] addr_reg, addr_next;
    logic [23:0] size_reg, size_next;
    logic [CW-1:0] count_reg, count_next;
    logic [22:0] bump_reg, bump_next;
    logic [22:0] base_reg, base_next;
    logic [22:0] top_reg, top_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic        pend_reg, pend_next;
    logic        found_reg, found_next;
    logic [CW-1:0] best_idx_reg, best_idx_next;
    bfra_pkg::entry_t best_reg, best_next;
    logic        prev_vld_reg, prev_vld_next;
    bfra_pkg::entry_t prev_reg, prev_next;
    logic        next_vld_reg, next_vld_next;
    bfra_pkg::entry_t next_reg, next_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic        dir_up_reg, dir_up_next;
    logic [CW-1:0] left_reg, left_next;
    logic [21:0] res_grant_reg, res_grant_next;
    logic        res_fail_reg, res_fail_next;
    logic        m_valid_reg, m_valid_next;
    logic [21:0] m_grant_reg, m_grant_next;
    logic        m_fail_reg, m_fail_next;
    logic [8:0]  m_blocks_reg, m_blocks_next;

    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    bfra_pkg::entry_t ram_wdata, rd_data;

    logic        accept;
    logic [23:0] size_rnd, room, size_free;
    logic [21:0] addr_in;
    logic        issue;
    logic        hit;
    logic [24:0] bump_sum;
    logic [22:0] limit;
    logic        merge_prev, merge_next;

    bfra_ram #(
        .WIDTH($bits(bfra_pkg::entry_t)),
        .DEPTH(FREE_ENTRIES)
    ) u_list (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(rd_data)
    );

    assign s_tready = (state_reg == bfra_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_blocks_reg, m_grant_reg};
    assign m_tuser  = m_fail_reg;

    // Round the size up to the grain and clip a freed range at the end of memory.
    assign addr_in   = s_tdata[21:0];
    assign size_rnd  = ({1'b0, s_tdata[44:22]} + bfra_pkg::GRAIN_MASK) & ~bfra_pkg::GRAIN_MASK;
    assign room      = bfra_pkg::MEM_END - {2'b00, addr_in};
    assign size_free = (size_rnd > room) ? room : size_rnd;

    // Bump allocation check and merge conditions, all from registered values.
    assign limit      = (top_reg < bfra_pkg::MEM_END[22:0]) ? top_reg : bfra_pkg::MEM_END[22:0];
    assign bump_sum   = {2'b00, bump_reg} + {1'b0, size_reg};
    assign merge_prev = prev_vld_reg &&
                        (({2'b00, prev_reg.start} + {1'b0, prev_reg.len}) == {2'b00, addr_reg});
    assign merge_next = next_vld_reg &&
                        (({2'b00, addr_reg} + size_reg) == {2'b00, next_reg.start});
    assign hit        = pend_reg && (rd_data.start >= addr_reg);

    // Controller next-state logic.
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        size_next     = size_reg;
        count_next    = count_reg;
        bump_next     = bump_reg;
        base_next     = base_reg;
        top_next      = top_reg;
        rd_idx_next   = rd_idx_reg;
        pidx_next     = pidx_reg;
        pend_next     = 1'b0;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        prev_vld_next = prev_vld_reg;
        prev_next     = prev_reg;
        next_vld_next = next_vld_reg;
        next_next     = next_reg;
        pos_next      = pos_reg;
        dir_up_next   = dir_up_reg;
        left_next     = left_reg;
        res_grant_next = res_grant_reg;
        res_fail_next  = res_fail_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_grant_next  = m_grant_reg;
        m_fail_next   = m_fail_reg;
        m_blocks_next = m_blocks_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        issue         = 1'b0;

        // The user must write configuration only while the block is idle; the block itself does not enforce it.
        if (cfg_we) begin
            if (cfg_index == bfra_pkg::REG_ARENA_BASE) begin
                base_next = cfg_wdata;
            end else begin
                top_next = cfg_wdata;
            end
        end

        case (state_reg)
            bfra_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next        = s_tuser;
                    addr_next      = addr_in;
                    size_next      = (s_tuser == bfra_pkg::OP_FREE) ? size_free : size_rnd;
                    rd_idx_next    = '0;
                    found_next     = 1'b0;
                    prev_vld_next  = 1'b0;
                    next_vld_next  = 1'b0;
                    res_grant_next = '0;
                    res_fail_next  = 1'b0;
                    case (s_tuser)
                        bfra_pkg::OP_ALLOC: begin
                            if (size_rnd == '0) begin
                                res_fail_next = 1'b1;
                                state_next    = bfra_pkg::ST_DONE;
                            end else begin
                                state_next = bfra_pkg::ST_SCAN;
                            end
                        end
                        bfra_pkg::OP_FREE: begin
                            if (size_rnd == '0 || count_reg >= CW'(FREE_ENTRIES)) begin
                                res_fail_next = 1'b1;
                                state_next    = bfra_pkg::ST_DONE;
                            end else begin
                                state_next = bfra_pkg::ST_SCAN;
                            end
                        end
                        bfra_pkg::OP_EVICT: begin
                            count_next = '0;
                            bump_next  = base_reg;
                            state_next = bfra_pkg::ST_DONE;
                        end
                        default: begin
                            res_fail_next = 1'b1;
                            state_next    = bfra_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            bfra_pkg::ST_SCAN: begin
                // Stream the list out one entry a cycle.
                issue = (rd_idx_reg < count_reg) && !(op_reg == bfra_pkg::OP_FREE && hit);
                if (issue) begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg[IW-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pidx_next   = rd_idx_reg;
                    pend_next   = 1'b1;
                end
                if (pend_reg) begin
                    if (op_reg == bfra_pkg::OP_ALLOC) begin
                        // Smallest block that fits, the lowest position on a tie.
                        if ({1'b0, rd_data.len} >= size_reg &&
                            (!found_reg || rd_data.len < best_reg.len)) begin
                            found_next    = 1'b1;
                            best_idx_next = pidx_reg;
                            best_next     = rd_data;
                        end
                    end else if (hit) begin
                        next_vld_next = 1'b1;
                        next_next     = rd_data;
                        pos_next      = pidx_reg;
                        pend_next     = 1'b0;
                        state_next    = bfra_pkg::ST_DECIDE;
                    end else begin
                        prev_vld_next = 1'b1;
                        prev_next     = rd_data;
                    end
                end
                if (!issue && !pend_reg) begin
                    pos_next   = count_reg;
                    state_next = bfra_pkg::ST_DECIDE;
                end
            end

            bfra_pkg::ST_DECIDE: begin
                if (op_reg == bfra_pkg::OP_ALLOC) begin
                    if (found_reg) begin
                        res_grant_next = best_reg.start;
                        if ({1'b0, best_reg.len} == size_reg) begin
                            // Exact fit: close the gap above the taken entry.
                            dir_up_next = 1'b0;
                            rd_idx_next = best_idx_reg + 1'b1;
                            left_next   = count_reg - best_idx_reg - 1'b1;
                            state_next  = bfra_pkg::ST_SHIFT;
                        end else begin
                            ram_we          = 1'b1;
                            ram_waddr       = best_idx_reg[IW-1:0];
                            ram_wdata.start = best_reg.start + size_reg[21:0];
                            ram_wdata.len   = best_reg.len - size_reg[22:0];
                            state_next      = bfra_pkg::ST_DONE;
                        end
                    end else if (bump_sum > {2'b00, limit}) begin
                        res_fail_next = 1'b1;
                        state_next    = bfra_pkg::ST_DONE;
                    end else begin
                        res_grant_next = bump_reg[21:0];
                        bump_next      = bump_sum[22:0];
                        state_next     = bfra_pkg::ST_DONE;
                    end
                end else begin
                    state_next = bfra_pkg::ST_DONE;
                    if (merge_prev && merge_next) begin
                        // The freed range bridges two entries: fold all into the lower one.
                        ram_we          = 1'b1;
                        ram_waddr       = IW'(pos_reg - 1'b1);
                        ram_wdata.start = prev_reg.start;
                        ram_wdata.len   = prev_reg.len + size_reg[22:0] + next_reg.len;
                        dir_up_next     = 1'b0;
                        rd_idx_next     = pos_reg + 1'b1;
                        left_next       = count_reg - pos_reg - 1'b1;
                        state_next      = bfra_pkg::ST_SHIFT;
                    end else if (merge_prev) begin
                        ram_we          = 1'b1;
                        ram_waddr       = IW'(pos_reg - 1'b1);
                        ram_wdata.start = prev_reg.start;
                        ram_wdata.len   = prev_reg.len + size_reg[22:0];
                    end else if (merge_next) begin
                        ram_we          = 1'b1;
                        ram_waddr       = pos_reg[IW-1:0];
                        ram_wdata.start = addr_reg;
                        ram_wdata.len   = size_reg[22:0] + next_reg.len;
                    end else begin
                        // Plain insert: open a slot at the insertion point first.
                        dir_up_next = 1'b1;
                        rd_idx_next = count_reg - 1'b1;
                        left_next   = count_reg - pos_reg;
                        state_next  = bfra_pkg::ST_SHIFT;
                    end
                end
            end

            bfra_pkg::ST_SHIFT: begin
                // Move entries one place; each entry is written in the cycle after it is read.
                issue = (left_reg != '0);
                if (issue) begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg[IW-1:0];
                    rd_idx_next = dir_up_reg ? rd_idx_reg - 1'b1 : rd_idx_reg + 1'b1;
                    left_next   = left_reg - 1'b1;
                    pidx_next   = rd_idx_reg;
                    pend_next   = 1'b1;
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = dir_up_reg ? IW'(pidx_reg + 1'b1) : IW'(pidx_reg - 1'b1);
                    ram_wdata = rd_data;
                end else if (!issue) begin
                    if (dir_up_reg) begin
                        ram_we          = 1'b1;
                        ram_waddr       = pos_reg[IW-1:0];
                        ram_wdata.start = addr_reg;
                        ram_wdata.len   = size_reg[22:0];
                        count_next      = count_reg + 1'b1;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                    state_next = bfra_pkg::ST_DONE;
                end
            end

            bfra_pkg::ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_grant_next  = res_grant_reg;
                    m_fail_next   = res_fail_reg;
                    m_blocks_next = 9'(32'(count_reg));
                    state_next    = bfra_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bfra_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfra_pkg::ST_IDLE;
            count_reg   <= '0;
            bump_reg    <= '0;
            base_reg    <= '0;
            top_reg     <= bfra_pkg::MEM_END[22:0];
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            bump_reg    <= bump_next;
            base_reg    <= base_next;
            top_reg     <= top_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        size_reg      <= size_next;
        rd_idx_reg    <= rd_idx_next;
        pidx_reg      <= pidx_next;
        found_reg     <= found_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        prev_vld_reg  <= prev_vld_next;
        prev_reg      <= prev_next;
        next_vld_reg  <= next_vld_next;
        next_reg      <= next_next;
        pos_reg       <= pos_next;
        dir_up_reg    <= dir_up_next;
        left_reg      <= left_next;
        res_grant_reg <= res_grant_next;
        res_fail_reg  <= res_fail_next;
        m_grant_reg   <= m_grant_next;
        m_fail_reg    <= m_fail_next;
        m_blocks_reg  <= m_blocks_next;
    end

endmodule

// File: design/bfra_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module bfra_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/bfra_checker.sv
// Port-level checks for the best-fit range allocator, bound to the top level.
// Depends on best_fit_range_allocator_top.
module bfra_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A result waiting for the sink stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A failed transaction never carries a grant.
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[21:0] == 22'd0)
        else $error("failed result with nonzero grant");

    // The block works on one transaction at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

endmodule

bind best_fit_range_allocator_top bfra_checker u_bfra_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
